// ===== sv/mmsu_pkg.sv =====
// mmsu_pkg: shared types, constants and register codes for the min-max scaler
// used by mmsu_ctrl, mmsu_datapath and min_max_scale_to_unit_range
// no dependencies
package mmsu_pkg;

  localparam int DEF_SET_DEPTH = 64;
  localparam int DEF_FRAC_BITS = 14;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // quotient bits produced by the divider, two per step
  localparam int QUOT_W    = 18;
  localparam int DIV_STEPS = QUOT_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MODE = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scaled;
    logic                       end_of_set;
    logic                       degenerate;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PREP1,
    S_PREP2,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_fixed;  // capture sample for immediate scaling
    logic store_auto;  // buffer sample, update running min/max
    logic rd_start;    // rewind read pointer
    logic rd_en;       // read store at pointer
    logic rd_next;     // advance read pointer
    logic prep1;       // range and numerator
    logic prep2;       // magnitude, rounding offset, dividend
    logic div_step;    // two quotient bits
    logic emit;        // saturate and register result
    logic clear_set;   // empty the buffered set
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;      // fixed range mode
    logic rd_final;  // read pointer is at the last stored sample
  } dp_stat_t;

endpackage

// ===== sv/mmsu_ctrl.sv =====
// mmsu_ctrl: sequencer for the min-max scaler
// drives mmsu_datapath through ctrl_cmd_t, depends on mmsu_pkg
module mmsu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_last,
  input  mmsu_pkg::dp_stat_t   stat,
  output mmsu_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import mmsu_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.mode) begin
            state_next = S_PREP1;
          end else if (is_last) begin
            state_next = S_READ;
          end
        end
      end
      S_READ:  state_next = S_PREP1;
      S_PREP1: state_next = S_PREP2;
      S_PREP2: begin
        state_next = S_DIV;
        step_next  = '0;
      end
      S_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_OUT: begin
        if (stat.mode || stat.rd_final) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_fixed = stat.mode;
          cmd.store_auto = !stat.mode;
          cmd.rd_start   = !stat.mode && is_last;
        end
      end
      S_READ:  cmd.rd_en    = 1'b1;
      S_PREP1: cmd.prep1    = 1'b1;
      S_PREP2: cmd.prep2    = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_OUT: begin
        cmd.emit      = 1'b1;
        cmd.rd_next   = !stat.mode && !stat.rd_final;
        cmd.clear_set = !stat.mode && stat.rd_final;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/mmsu_datapath.sv =====
// mmsu_datapath: config registers, sample store, running min/max and
// the restoring divider that scales one sample; depends on mmsu_pkg
module mmsu_datapath #(
  parameter int SET_DEPTH = mmsu_pkg::DEF_SET_DEPTH,
  parameter int FRAC_BITS = mmsu_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mmsu_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [mmsu_pkg::CFG_W-1:0]    wr_data,
  input  mmsu_pkg::in_item_t            item,
  input  mmsu_pkg::ctrl_cmd_t           cmd,
  output mmsu_pkg::dp_stat_t            stat,
  output mmsu_pkg::result_t             result,
  output logic                          result_valid
);
  import mmsu_pkg::*;

  localparam int AW  = $clog2(SET_DEPTH);
  localparam int CW  = $clog2(SET_DEPTH + 1);
  localparam int NW  = 19 + FRAC_BITS;       // dividend width
  localparam int HIW = NW - QUOT_W;          // dividend bits above the quotient

  // configuration
  logic                       range_mode;
  logic signed [SAMPLE_W-1:0] range_low, range_high;

  // set state
  logic [SAMPLE_W-1:0]        sample_store [SET_DEPTH];
  logic [CW-1:0]              stored_count;
  logic signed [SAMPLE_W-1:0] running_min, running_max;
  logic [AW-1:0]              rd_ptr;
  logic [SAMPLE_W-1:0]        rd_data;

  // operand and arithmetic registers
  logic signed [SAMPLE_W-1:0] x_reg;
  logic                       last_reg;
  logic [15:0]                d_reg;
  logic                       deg_reg;
  logic signed [18:0]         n_reg;
  logic                       neg_reg;
  logic                       ovf_reg;
  logic [15:0]                rem;
  logic [QUOT_W-1:0]          low_bits;
  logic [QUOT_W-1:0]          quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode <= 1'b0;
      range_low  <= 16'sh8000;
      range_high <= 16'sh7fff;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RANGE_MODE: range_mode <= wr_data[0];
        REG_RANGE_LOW:  range_low  <= wr_data;
        REG_RANGE_HIGH: range_high <= wr_data;
        default: ;
      endcase
    end
  end

  logic store_room;
  assign store_room = (stored_count < CW'(SET_DEPTH));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      stored_count <= '0;
      running_min  <= 16'sh7fff;
      running_max  <= 16'sh8000;
    end else if (cmd.store_auto && store_room) begin
      stored_count <= stored_count + 1'b1;
      if (item.sample < running_min) running_min <= item.sample;
      if (item.sample > running_max) running_max <= item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_auto && store_room) begin
      sample_store[stored_count[AW-1:0]] <= item.sample;
    end
    if (cmd.rd_en) begin
      rd_data <= sample_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rd_start) begin
      rd_ptr <= '0;
    end else if (cmd.rd_next) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  assign stat.mode     = range_mode;
  assign stat.rd_final = ({1'b0, rd_ptr} + 1'b1) == stored_count;

  // first prep step: range width and numerator 2x - lo - hi
  logic signed [SAMPLE_W-1:0] x_sel, lo_sel, hi_sel;
  logic signed [16:0]         d_full;
  logic signed [18:0]         n_full;

  always_comb begin
    x_sel  = range_mode ? x_reg : rd_data;
    lo_sel = range_mode ? range_low : running_min;
    hi_sel = range_mode ? range_high : running_max;
    d_full = {hi_sel[15], hi_sel} - {lo_sel[15], lo_sel};
    n_full = {{2{x_sel[15]}}, x_sel, 1'b0} - {{3{lo_sel[15]}}, lo_sel}
           - {{3{hi_sel[15]}}, hi_sel};
  end

  // second prep step: |n| scaled by the fraction, plus half the range for rounding
  logic [18:0]    n_abs;
  logic [NW-1:0]  dividend;

  always_comb begin
    n_abs    = n_reg[18] ? (~n_reg + 19'd1) : n_reg;
    dividend = (NW'(n_abs[17:0]) << FRAC_BITS) + NW'(d_reg[15:1]);
  end

  // two restoring steps per cycle
  logic [15:0]       rem_step [3];
  logic [QUOT_W-1:0] low_step [3];
  logic [1:0]        qbits;
  logic [16:0]       trial;

  always_comb begin
    rem_step[0] = rem;
    low_step[0] = low_bits;
    qbits       = '0;
    trial       = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_step[i], low_step[i][QUOT_W-1]};
      if (trial >= {1'b0, d_reg}) begin
        rem_step[i+1] = 16'(trial - {1'b0, d_reg});
        qbits[1-i]    = 1'b1;
      end else begin
        rem_step[i+1] = trial[15:0];
      end
      low_step[i+1] = {low_step[i][QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fixed) begin
      x_reg    <= item.sample;
      last_reg <= item.is_last;
    end
    if (cmd.rd_en) begin
      last_reg <= stat.rd_final;
    end
    if (cmd.prep1) begin
      d_reg   <= d_full[15:0];
      deg_reg <= d_full[16] || (d_full == '0);
      n_reg   <= n_full;
    end
    if (cmd.prep2) begin
      neg_reg  <= n_reg[18];
      ovf_reg  <= {(17-HIW)'(0), dividend[NW-1:QUOT_W]} >= {1'b0, d_reg};
      rem      <= 16'(dividend[NW-1:QUOT_W]);
      low_bits <= dividend[QUOT_W-1:0];
      quot     <= '0;
    end
    if (cmd.div_step) begin
      rem      <= rem_step[2];
      low_bits <= low_step[2];
      quot     <= {quot[QUOT_W-3:0], qbits};
    end
  end

  // rounding already folded in, saturate to the signed output range
  logic [SAMPLE_W-1:0] scaled_val;

  always_comb begin
    if (deg_reg) begin
      scaled_val = '0;
    end else if (neg_reg) begin
      if (ovf_reg || quot > QUOT_W'(32768)) scaled_val = 16'h8000;
      else scaled_val = ~quot[15:0] + 16'd1;
    end else begin
      if (ovf_reg || quot > QUOT_W'(32767)) scaled_val = 16'h7fff;
      else scaled_val = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      result.scaled     <= scaled_val;
      result.end_of_set <= last_reg;
      result.degenerate <= deg_reg;
    end
  end

endmodule

// ===== sv/min_max_scale_to_unit_range.sv =====
// min_max_scale_to_unit_range: top level of the min-max scaler to -1..+1
// holds mmsu_ctrl and mmsu_datapath, depends on mmsu_pkg
//
//   channel   ports                              handshake
//   input     item.sample, item.is_last          start && !busy
//   result    result.scaled/end_of_set/degenerate result_valid, one cycle
//   config    wr_index, wr_data                  wr_en
//
// auto mode: a sample without is_last is buffered and busy stays low.
// each result passes a store read, a first and a second prep step, the
// divider steps at two quotient bits each and an output step, and a set
// is drained one sample after another; fixed mode skips the store read.
// the divider is the limit. reset is synchronous; the receiver cannot stall.
module min_max_scale_to_unit_range #(
  parameter int SET_DEPTH = mmsu_pkg::DEF_SET_DEPTH,
  parameter int FRAC_BITS = mmsu_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mmsu_pkg::in_item_t             item,
  output mmsu_pkg::result_t              result,
  output logic                           result_valid,
  input  logic                           wr_en,
  input  logic [mmsu_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [mmsu_pkg::CFG_W-1:0]     wr_data
);
  import mmsu_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mmsu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (item.is_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  mmsu_datapath #(
    .SET_DEPTH (SET_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  // every result strobe comes from an output step of the sequencer
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.emit))
    else $error("result strobe without output step");

  // buffering a sample that does not close the set keeps the block free
  a_auto_fill_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !stat.mode && !item.is_last) |=> !busy)
    else $error("busy after buffering a sample");

  // busy only rises after an accepted transaction
  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // a fixed-range transaction always occupies the block
  a_fixed_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && stat.mode) |=> busy)
    else $error("fixed transaction not started");

endmodule

// ===== verif/min_max_scale_to_unit_range_test.sv =====
`timescale 1ns / 100ps
// min_max_scale_to_unit_range_test: self-checking bench for the min-max scaler
// directed table then random sets in auto and fixed mode, scored by a local model
// depends on mmsu_pkg and min_max_scale_to_unit_range
module min_max_scale_to_unit_range_test;
  import mmsu_pkg::*;

  localparam int DEPTH       = DEF_SET_DEPTH;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int HOLD_CYC    = 16;
  localparam int DRAIN_CYC   = 20;
  localparam int QUIET_LIMIT = 1000;
  localparam int DIR_ROWS    = 22;
  localparam int RAND_PER_PH = 55;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  result_t              result;
  logic                 result_valid;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  min_max_scale_to_unit_range u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result(result),
    .result_valid(result_valid),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // scaler model state
  logic signed [15:0] held_samples [DEPTH];
  int                 held_cnt;
  int                 held_min;
  int                 held_max;
  bit                 cfg_fixed;
  int                 cfg_lo;
  int                 cfg_hi;
  result_t            pending_scaled [$];

  int idle_pct;
  int smp_cnt;
  int res_cnt;
  int drained_sets;
  int cfg_cnt;
  int err_cnt;
  int quiet_cycles;

  typedef struct {
    bit mode;
    int lo;
    int hi;
    int smp;
    bit last;
    bit typed;
    int e_scaled;
    bit e_eos;
    bit e_deg;
  } dir_row_t;

  //   mode lo      hi     sample  last typed scaled eos deg
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{0, -32768, 32767, -32768, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,  32767, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,      0, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,     -1, 1, 0,      0, 0, 0},
    '{0, -32768, 32767,      5, 1, 1,      0, 1, 1},
    '{0, -32768, 32767,      7, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,      7, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,      7, 1, 0,      0, 0, 0},
    '{0, -32768, 32767,     10, 0, 0,      0, 0, 0},
    '{0, -32768, 32767,     20, 0, 0,      0, 0, 0},
    '{1, -32768, 32767,      0, 0, 1,      0, 0, 0},
    '{0, -32768, 32767,     30, 1, 0,      0, 0, 0},
    '{1, -32768, 32767, -32768, 0, 1, -16384, 0, 0},
    '{1, -32768, 32767,  32767, 1, 1,  16384, 1, 0},
    '{1,   -100,   100,  32767, 0, 1,  32767, 0, 0},
    '{1,   -100,   100, -32768, 1, 1, -32768, 1, 0},
    '{1,   -100,   100,    100, 0, 1,  16384, 0, 0},
    '{1,   -100,   100,   -100, 0, 1, -16384, 0, 0},
    '{1,   -100,   100,     37, 1, 0,      0, 0, 0},
    '{1,      5,     5,   1234, 1, 1,      0, 1, 1},
    '{1,  32767, -32768, -32768, 0, 1,     0, 0, 1},
    '{1, -32768, -32767,     0, 1, 0,      0, 0, 0}
  };

  function automatic result_t scale_to_unit(int x, int lo, int hi, bit last);
    longint  span;
    longint  num;
    longint  mag;
    longint  quo;
    longint  q;
    result_t r;
    span = longint'(hi) - longint'(lo);
    r.end_of_set = last;
    if (span <= 0) begin
      r.scaled     = '0;
      r.degenerate = 1'b1;
      return r;
    end
    num = 2 * (longint'(x) - longint'(lo)) - span;
    mag = (num < 0 ? -num : num) <<< FRAC;
    quo = (mag + span / 2) / span;
    if (num < 0) q = (quo > 32768) ? -32768 : -quo;
    else         q = (quo > 32767) ? 32767 : quo;
    r.scaled     = q[15:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic clear_held();
    held_cnt = 0;
    held_min = 32767;
    held_max = -32768;
  endtask

  task automatic model_sample(input in_item_t txn);
    int x;
    x = int'(txn.sample);
    if (cfg_fixed) begin
      pending_scaled.push_back(scale_to_unit(x, cfg_lo, cfg_hi, txn.is_last));
    end else begin
      // full store drops the sample, but is_last still drains
      if (held_cnt < DEPTH) begin
        held_samples[held_cnt] = txn.sample;
        held_cnt++;
        if (x < held_min) held_min = x;
        if (x > held_max) held_max = x;
      end
      if (txn.is_last) begin
        for (int i = 0; i < held_cnt; i++)
          pending_scaled.push_back(scale_to_unit(int'(held_samples[i]), held_min,
                                                 held_max, i + 1 == held_cnt));
        drained_sets++;
        clear_held();
      end
    end
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // writes all three registers once the scaler has gone quiet
  task automatic apply_cfg(input bit mode, input logic signed [15:0] lo,
                           input logic signed [15:0] hi);
    start <= 1'b0;
    while (pending_scaled.size() != 0) @(negedge clk);
    repeat (HOLD_CYC) @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_RANGE_MODE;
    wr_data  <= {{(CFG_W-1){1'b0}}, mode};
    @(negedge clk);
    wr_index <= REG_RANGE_LOW;
    wr_data  <= lo;
    @(negedge clk);
    wr_index <= REG_RANGE_HIGH;
    wr_data  <= hi;
    @(negedge clk);
    wr_en <= 1'b0;
    cfg_fixed = mode;
    cfg_lo    = int'(lo);
    cfg_hi    = int'(hi);
    cfg_cnt++;
  endtask

  task automatic send_sample(input logic signed [15:0] smp, input bit last,
                             input bit typed, input result_t typed_want);
    in_item_t txn;
    int       base_n;
    txn.sample  = smp;
    txn.is_last = last;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item  <= txn;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    base_n = pending_scaled.size();
    model_sample(txn);
    // hand-written expectation replaces the modeled one
    if (typed && pending_scaled.size() > base_n) pending_scaled[base_n] = typed_want;
    smp_cnt++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      res_cnt++;
      if (pending_scaled.size() == 0) begin
        note_error($sformatf("unexpected result scaled=%0d eos=%b deg=%b",
                             result.scaled, result.end_of_set, result.degenerate));
      end else begin
        want = pending_scaled.pop_front();
        if (result.scaled !== want.scaled || result.end_of_set !== want.end_of_set ||
            result.degenerate !== want.degenerate)
          note_error($sformatf(
            "result %0d: exp scaled=%0d eos=%b deg=%b, got scaled=%0d eos=%b deg=%b",
            res_cnt, want.scaled, want.end_of_set, want.degenerate,
            result.scaled, result.end_of_set, result.degenerate));
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, pending_scaled.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    result_t            typed_want;
    logic signed [15:0] lo_r;
    logic signed [15:0] hi_r;
    logic signed [15:0] s;
    int                 budget;
    int                 len;
    int                 style;
    int                 base;
    int                 v;

    clk      = 1'b0;
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    wr_en    = 1'b0;
    wr_index = REG_RANGE_MODE;
    wr_data  = '0;
    idle_pct = 6;
    smp_cnt  = 0;
    res_cnt  = 0;
    drained_sets = 0;
    cfg_cnt  = 0;
    err_cnt  = 0;
    quiet_cycles = 0;
    cfg_fixed = 1'b0;
    cfg_lo    = -32768;
    cfg_hi    = 32767;
    clear_held();

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || dir_tab[i].mode != cfg_fixed || dir_tab[i].lo != cfg_lo ||
          dir_tab[i].hi != cfg_hi)
        apply_cfg(dir_tab[i].mode, 16'(dir_tab[i].lo), 16'(dir_tab[i].hi));
      typed_want.scaled     = 16'(dir_tab[i].e_scaled);
      typed_want.end_of_set = dir_tab[i].e_eos;
      typed_want.degenerate = dir_tab[i].e_deg;
      send_sample(16'(dir_tab[i].smp), dir_tab[i].last, dir_tab[i].typed, typed_want);
    end

    // random phases, sender gap rate goes from 6 to 66 to none
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 6 : (ph < 4) ? 66 : 0;
      case (ph)
        0: begin
          lo_r = 16'($urandom());
          hi_r = 16'($urandom());
          apply_cfg(1'b0, lo_r, hi_r);
        end
        1: apply_cfg(1'b1, -16'sd32767 - 16'sd1, 16'sd32767);
        2: apply_cfg(1'b0, 16'sd32767, -16'sd32767 - 16'sd1);
        3: begin
          lo_r = 16'($urandom());
          hi_r = 16'($urandom());
          apply_cfg(1'b1, lo_r, hi_r);
        end
        4: apply_cfg(1'b0, 16'sd0, 16'sd0);
        default: begin
          v    = int'($urandom_range(64000)) - 32768;
          lo_r = 16'(v);
          hi_r = 16'(v + int'($urandom_range(300, 1)));
          apply_cfg(1'b1, lo_r, hi_r);
        end
      endcase

      budget = 0;
      while (budget < RAND_PER_PH) begin
        if (cfg_fixed) begin
          if (cfg_lo < cfg_hi && $urandom_range(1) == 1)
            s = 16'(cfg_lo + int'($urandom_range(cfg_hi - cfg_lo)));
          else
            s = 16'($urandom());
          send_sample(s, 1'($urandom_range(1)), 1'b0, '0);
          budget++;
        end else begin
          // mostly short sets, now and then a long one that may overfill the store
          len   = ($urandom_range(9) == 0) ? int'($urandom_range(68, 62))
                                           : int'($urandom_range(8, 1));
          style = $urandom_range(3);
          base  = int'($signed(16'($urandom())));
          for (int k = 0; k < len; k++) begin
            case (style)
              0: v = int'($signed(16'($urandom())));
              1: begin
                v = base + int'($urandom_range(40)) - 20;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
              end
              2: v = base;
              default: begin
                case ($urandom_range(3))
                  0: v = -32768;
                  1: v = 32767;
                  2: v = 0;
                  default: v = int'($signed(16'($urandom())));
                endcase
              end
            endcase
            send_sample(16'(v), k == len - 1, 1'b0, '0);
            budget++;
          end
        end
      end
    end

    start <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("run covered %0d samples and %0d checked results over %0d register settings",
             smp_cnt, res_cnt, cfg_cnt);
    $display("auto mode drained %0d sets, %0d errors found", drained_sets, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
